// ----- sv/rpme_pkg.sv -----
// ---------------------------------------------------------------------------
// rpme_pkg: shared types and constants of the Rayleigh phase matrix evaluator
// Fixed Q30 arithmetic constants, series coefficients and pipeline structs.
// ---------------------------------------------------------------------------
package rpme_pkg;

    // Fixed point: internal magnitudes are Q30
    localparam int          Q      = 30;
    localparam logic [30:0] ONE_Q  = 31'h4000_0000;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;

    // Angle codes in units of pi/65536
    localparam logic [16:0] ANGLE_PI   = 17'd65536;
    localparam logic [16:0] ANGLE_HALF = 17'd32768;
    localparam logic [16:0] ANGLE_QTR  = 17'd16384;

    // Register indexes
    localparam logic CFG_ISO = 1'b0;
    localparam logic CFG_DEP = 1'b1;

    // Taylor divisors per series step, cosine and sine
    localparam int unsigned K_COS [5] = '{90, 56, 30, 12, 2};
    localparam int unsigned K_SIN [5] = '{110, 72, 42, 20, 6};

    // Per-word flags that travel down the pipe
    typedef struct packed {
        logic valid;
        logic err;
        logic cneg;
    } t_flags;

    // Series section payload
    typedef struct packed {
        t_flags      fl;
        logic        is_sin;
        logic [29:0] x;
        logic [29:0] x2;
    } t_cpipe;

endpackage

// ----- sv/rpme_div.sv -----
// ---------------------------------------------------------------------------
// rpme_div: depolarization coefficient divider
// Bit-serial restoring division that forms delta and delta*delta' in Q30
// from the depolarization factor, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rpme_div import rpme_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dep,
    output logic        o_busy,
    output logic [30:0] o_delta,
    output logic [30:0] o_dd,
    output logic        o_ddneg
);

    localparam int NW = 48;

    logic [NW-1:0] r_num_a, r_num_b;
    logic [17:0]   r_den;
    logic [18:0]   r_rem_a, r_rem_b;
    logic [30:0]   r_q_a, r_q_b;
    logic [5:0]    r_cnt;
    logic          r_ddneg;

    logic [17:0]   den;
    logic [16:0]   dd_num;
    logic          dd_neg;
    logic [18:0]   sh_a, sh_b;

    // Set up numerators with the half-up rounding term
    always_comb begin
        den    = 18'd131072 + {2'b0, i_dep};
        dd_neg = ({1'b0, i_dep, 1'b0} > {1'b0, ANGLE_PI});
        dd_num = dd_neg ? ({i_dep, 1'b0} - ANGLE_PI) : (ANGLE_PI - {i_dep, 1'b0});
        sh_a   = {r_rem_a[17:0], r_num_a[NW-1]};
        sh_b   = {r_rem_b[17:0], r_num_b[NW-1]};
    end

    // Shift one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_q_a   <= ONE_Q;
            r_q_b   <= ONE_Q;
            r_ddneg <= 1'b0;
        end else if (i_start) begin
            r_cnt   <= 6'(NW);
            r_den   <= den;
            r_num_a <= ({31'b0, ANGLE_PI - {1'b0, i_dep}} << 31) + {31'b0, den[17:1]};
            r_num_b <= ({31'b0, dd_num} << 31) + {31'b0, den[17:1]};
            r_rem_a <= '0;
            r_rem_b <= '0;
            r_ddneg <= dd_neg;
        end else if (r_cnt != '0) begin
            r_cnt   <= r_cnt - 6'd1;
            r_num_a <= {r_num_a[NW-2:0], 1'b0};
            r_num_b <= {r_num_b[NW-2:0], 1'b0};
            if (sh_a >= {1'b0, r_den}) begin
                r_rem_a <= sh_a - {1'b0, r_den};
                r_q_a   <= {r_q_a[29:0], 1'b1};
            end else begin
                r_rem_a <= sh_a;
                r_q_a   <= {r_q_a[29:0], 1'b0};
            end
            if (sh_b >= {1'b0, r_den}) begin
                r_rem_b <= sh_b - {1'b0, r_den};
                r_q_b   <= {r_q_b[29:0], 1'b1};
            end else begin
                r_rem_b <= sh_b;
                r_q_b   <= {r_q_b[29:0], 1'b0};
            end
        end
    end

    assign o_busy  = (r_cnt != '0);
    assign o_delta = r_q_a;
    assign o_dd    = r_q_b;
    assign o_ddneg = r_ddneg;

endmodule

// ----- sv/rpme_step.sv -----
// ---------------------------------------------------------------------------
// rpme_step: one nested Taylor step, t = ONE - (x2*t)/k
// Three register stages: product, reciprocal multiply, correct and subtract.
// ---------------------------------------------------------------------------
module rpme_step import rpme_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_cpipe      i_ctl,
    input  logic [30:0] i_t,
    output t_cpipe      o_ctl,
    output logic [30:0] o_t
);

    localparam logic [6:0]  K_C = 7'(K_COS[STEP]);
    localparam logic [6:0]  K_S = 7'(K_SIN[STEP]);
    localparam logic [31:0] M_C = 32'((64'd1 << 32) / K_COS[STEP]);
    localparam logic [31:0] M_S = 32'((64'd1 << 32) / K_SIN[STEP]);

    t_cpipe      r_a_ctl, r_b_ctl, r_c_ctl;
    logic [29:0] r_a_p, r_b_p, r_b_qe;
    logic [30:0] r_c_t;

    logic [60:0] prod_a;
    logic [61:0] prod_b;
    logic [6:0]  k;
    logic [36:0] qk, rem;
    logic [29:0] q;

    // Product, reciprocal estimate, exact truncating correction
    always_comb begin
        prod_a = {30'b0, i_ctl.x2} * {30'b0, i_t};
        prod_b = {32'b0, r_a_p} * {30'b0, (r_a_ctl.is_sin ? M_S : M_C)};
        k      = r_b_ctl.is_sin ? K_S : K_C;
        qk     = {7'b0, r_b_qe} * {30'b0, k};
        rem    = {7'b0, r_b_p} - qk;
        q      = r_b_qe + {29'b0, (rem >= {30'b0, k})};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl.fl.valid <= 1'b0;
            r_b_ctl.fl.valid <= 1'b0;
            r_c_ctl.fl.valid <= 1'b0;
        end else if (i_en) begin
            r_a_ctl <= i_ctl;
            r_a_p   <= prod_a[59:30];
            r_b_ctl <= r_a_ctl;
            r_b_p   <= r_a_p;
            r_b_qe  <= prod_b[61:32];
            r_c_ctl <= r_b_ctl;
            r_c_t   <= ONE_Q - {1'b0, q};
        end
    end

    assign o_ctl = r_c_ctl;
    assign o_t   = r_c_t;

endmodule

// ----- sv/rayleigh_phase_matrix_eval_top.sv -----
// ---------------------------------------------------------------------------
// rayleigh_phase_matrix_eval_top: Rayleigh phase matrix with depolarization
// Maps a scattering angle code to F11, F12, F22, F33, F44 in unsigned Q1.FRAC_BITS
// (F11, F22), signed Q1.FRAC_BITS (F33, F44) and signed Q0.FRAC_BITS (F12).
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   angle   | i_in_valid, o_in_ready, i_angle_code  | in
//   matrix  | o_out_valid, i_out_ready, o_f11..o_f44,| out
//           | o_angle_error                         |
//   config  | i_cfg_we, i_cfg_idx, i_cfg_data       | in
//
// One word per cycle enters while o_in_ready is high; it passes through the cosine
// series pipeline (five three-stage Taylor steps) and the product stages.
// A depolarization write runs the serial divider; o_in_ready is low while it
// runs. Reset is synchronous; it clears valid bits and restores the d = 0
// coefficients at once. A stall on the output freezes the pipe.
// ---------------------------------------------------------------------------
module rayleigh_phase_matrix_eval_top import rpme_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [16:0]                 i_angle_code,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [FRAC_BITS:0]          o_f11,
    output logic signed [FRAC_BITS:0]   o_f12,
    output logic [FRAC_BITS:0]          o_f22,
    output logic signed [FRAC_BITS+1:0] o_f33,
    output logic signed [FRAC_BITS+1:0] o_f44,
    output logic                        o_angle_error,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [15:0]                 i_cfg_data
);

    localparam int          W_N = FRAC_BITS + 1;
    localparam int          W_W = FRAC_BITS + 2;
    localparam int          SH  = Q - FRAC_BITS;
    localparam logic [33:0] RND = 34'((64'd1 << SH) >> 1);

    // Round Q30 magnitude, apply sign
    function automatic logic [33:0] to_out(input logic [32:0] mag, input logic neg);
        logic [33:0] m;
        m = ({1'b0, mag} + RND) >> SH;
        return neg ? (34'd0 - m) : m;
    endfunction

    logic        en;
    logic        busy;
    logic        r_iso;
    logic [30:0] delta, dd;
    logic        ddneg;

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso <= 1'b0;
        end else if (i_cfg_we && i_cfg_idx == CFG_ISO) begin
            r_iso <= i_cfg_data[0];
        end
    end

    rpme_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we && i_cfg_idx == CFG_DEP),
        .i_dep   (i_cfg_data),
        .o_busy  (busy),
        .o_delta (delta),
        .o_dd    (dd),
        .o_ddneg (ddneg)
    );

    // Advance the whole pipe unless the output word is held
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en && !busy;

    // Stage 0: range check and octant reduction
    t_flags      r0_fl;
    logic        r0_sin;
    logic [14:0] r0_a;
    logic [16:0] red;
    logic        cneg, is_sin;
    logic [16:0] arg;

    always_comb begin
        cneg   = i_angle_code > ANGLE_HALF;
        red    = cneg ? (ANGLE_PI - i_angle_code) : i_angle_code;
        is_sin = red > ANGLE_QTR;
        arg    = is_sin ? (ANGLE_HALF - red) : red;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_fl.valid <= 1'b0;
        end else if (en) begin
            r0_fl.valid <= i_in_valid && o_in_ready;
            r0_fl.err   <= i_angle_code > ANGLE_PI;
            r0_fl.cneg  <= cneg;
            r0_sin      <= is_sin;
            r0_a        <= arg[14:0];
        end
    end

    // Stage 1: code to radians
    t_flags      r1_fl;
    logic        r1_sin;
    logic [29:0] r1_x;
    logic [46:0] rad;

    assign rad = ({17'b0, r0_a} * {15'b0, PI_Q30}) + 47'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_fl.valid <= 1'b0;
        end else if (en) begin
            r1_fl  <= r0_fl;
            r1_sin <= r0_sin;
            r1_x   <= rad[45:16];
        end
    end

    // Stage 2: square of the argument
    t_cpipe      r2_ctl;
    logic [59:0] xsq;

    assign xsq = {30'b0, r1_x} * {30'b0, r1_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl.fl.valid <= 1'b0;
        end else if (en) begin
            r2_ctl.fl     <= r1_fl;
            r2_ctl.is_sin <= r1_sin;
            r2_ctl.x      <= r1_x;
            r2_ctl.x2     <= xsq[59:30];
        end
    end

    // Nested series steps
    t_cpipe      s_ctl [6];
    logic [30:0] s_t   [6];

    assign s_ctl[0] = r2_ctl;
    assign s_t[0]   = ONE_Q;

    for (genvar g = 0; g < 5; g++) begin : g_step
        rpme_step #(.STEP(g)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (s_ctl[g]),
            .i_t     (s_t[g]),
            .o_ctl   (s_ctl[g+1]),
            .o_t     (s_t[g+1])
        );
    end

    // Sine finish and clamp
    t_flags      r3_fl;
    logic [30:0] r3_c;
    logic [60:0] xt;
    logic [30:0] c_raw;

    always_comb begin
        xt    = {31'b0, s_ctl[5].x} * {30'b0, s_t[5]};
        c_raw = s_ctl[5].is_sin ? xt[60:30] : s_t[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_fl.valid <= 1'b0;
        end else if (en) begin
            r3_fl <= s_ctl[5].fl;
            r3_c  <= (c_raw > ONE_Q) ? ONE_Q : c_raw;
        end
    end

    // Cosine squared
    t_flags      r4_fl;
    logic [30:0] r4_c, r4_c2;
    logic [61:0] csq;

    assign csq = {31'b0, r3_c} * {31'b0, r3_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_fl.valid <= 1'b0;
        end else if (en) begin
            r4_fl <= r3_fl;
            r4_c  <= r3_c;
            r4_c2 <= csq[60:30];
        end
    end

    // Coefficient products
    t_flags      r5_fl;
    logic [32:0] r5_pa;
    logic [30:0] r5_ps, r5_pc, r5_pd;
    logic [62:0] pa;
    logic [61:0] ps, pc, pd;

    always_comb begin
        pa = {32'b0, delta} * {31'b0, {1'b0, ONE_Q} + {1'b0, r4_c2}};
        ps = {31'b0, delta} * {31'b0, ONE_Q - r4_c2};
        pc = {31'b0, delta} * {31'b0, r4_c};
        pd = {31'b0, dd} * {31'b0, r4_c};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_fl.valid <= 1'b0;
        end else if (en) begin
            r5_fl <= r4_fl;
            r5_pa <= pa[62:30];
            r5_ps <= ps[60:30];
            r5_pc <= pc[60:30];
            r5_pd <= pd[60:30];
        end
    end

    // Output register: round, sign, select mode
    logic [32:0] p22, p11, p12, p33, p44;
    logic [33:0] v11, v12, v22, v33, v44;

    always_comb begin
        p22 = ({1'b0, r5_pa[31:0]} + {r5_pa[31:0], 1'b0} + {r5_pa[32], 32'b0}) >> 2;
        p11 = p22 + {2'b0, ONE_Q} - {2'b0, delta};
        p12 = ({2'b0, r5_ps} + {1'b0, r5_ps, 1'b0}) >> 2;
        p33 = ({2'b0, r5_pc} + {1'b0, r5_pc, 1'b0}) >> 1;
        p44 = ({2'b0, r5_pd} + {1'b0, r5_pd, 1'b0}) >> 1;
        v11 = to_out(p11, 1'b0);
        v22 = to_out(p22, 1'b0);
        v12 = to_out(p12, 1'b1);
        v33 = to_out(p33, r5_fl.cneg);
        v44 = to_out(p44, r5_fl.cneg ^ ddneg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid   <= r5_fl.valid;
            o_angle_error <= r5_fl.err;
            if (r5_fl.err) begin
                o_f11 <= '0;
                o_f12 <= '0;
                o_f22 <= '0;
                o_f33 <= '0;
                o_f44 <= '0;
            end else if (r_iso) begin
                o_f11 <= W_N'(1) << FRAC_BITS;
                o_f12 <= '0;
                o_f22 <= W_N'(1) << FRAC_BITS;
                o_f33 <= W_W'(1) << FRAC_BITS;
                o_f44 <= W_W'(1) << FRAC_BITS;
            end else begin
                o_f11 <= v11[W_N-1:0];
                o_f12 <= v12[W_N-1:0];
                o_f22 <= v22[W_N-1:0];
                o_f33 <= v33[W_W-1:0];
                o_f44 <= v44[W_W-1:0];
            end
        end
    end

endmodule

// ----- sv/rpme_checker.sv -----
// ---------------------------------------------------------------------------
// rpme_checker: port-level checks of the phase matrix evaluator
// Watches the top level's ports and is attached to it by bind.
// ---------------------------------------------------------------------------
module rpme_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [FRAC_BITS:0]          o_f11,
    input logic signed [FRAC_BITS:0]   o_f12,
    input logic [FRAC_BITS:0]          o_f22,
    input logic signed [FRAC_BITS+1:0] o_f33,
    input logic signed [FRAC_BITS+1:0] o_f44,
    input logic                        o_angle_error,
    input logic                        i_cfg_we,
    input logic                        i_cfg_idx
);

    // Output is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    // Held word stays valid with F11 and F44 unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_f11) && $stable(o_f44))
        else $error("stalled output word changed");

    // Bad angle gives an all-zero matrix
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_angle_error |->
            o_f11 == '0 && o_f12 == '0 && o_f22 == '0 && o_f33 == '0 && o_f44 == '0)
        else $error("angle error with nonzero elements");

    // F11 never falls below F22
    a_f11_ge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_angle_error |-> o_f11 >= o_f22)
        else $error("F11 below F22");

    // Depolarization write blocks input while the divider runs
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_idx |=> !o_in_ready)
        else $error("input ready during coefficient update");

endmodule

bind rayleigh_phase_matrix_eval_top rpme_checker #(.FRAC_BITS(FRAC_BITS)) u_rpme_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_f11         (o_f11),
    .o_f12         (o_f12),
    .o_f22         (o_f22),
    .o_f33         (o_f33),
    .o_f44         (o_f44),
    .o_angle_error (o_angle_error),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_idx     (i_cfg_idx)
);

// ----- test/rayleigh_phase_matrix_eval_top_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rayleigh_phase_matrix_eval_top_test: phase matrix evaluator testbench
// Sends angle codes through the valid/ready input channel. Each word is
// checked against a Q30 fixed-point model of the depolarized Rayleigh law
// and the isotropic matrix. Register settings change between phases, and
// random gaps and output stalls are applied.
// ---------------------------------------------------------------------------
module rayleigh_phase_matrix_eval_top_test;
    import rpme_pkg::*;

    localparam int FB          = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 30;

    typedef struct {
        logic [16:0] f11;
        logic [16:0] f12;
        logic [16:0] f22;
        logic [17:0] f33;
        logic [17:0] f44;
        logic        err;
    } t_matrix;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [16:0] i_angle_code;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [16:0] o_f11;
    logic signed [16:0] o_f12;
    logic [16:0] o_f22;
    logic signed [17:0] o_f33;
    logic signed [17:0] o_f44;
    logic        o_angle_error;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;

    // Local copy of the register file
    logic        iso_mode;
    logic [15:0] depol;

    t_matrix expected_matrix_q[$];
    int          mismatch_count;
    int          cycle_count;
    bit          calm;
    int          ready_hold;

    rayleigh_phase_matrix_eval_top #(.FRAC_BITS(FB)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_angle_code (i_angle_code),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_f11        (o_f11),
        .o_f12        (o_f12),
        .o_f22        (o_f22),
        .o_f33        (o_f33),
        .o_f44        (o_f44),
        .o_angle_error(o_angle_error),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Q30 product
    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    // Round a Q30 magnitude to FB fraction bits, apply the sign, mask
    function automatic logic [17:0] to_fixed(input logic [63:0] mag, input bit neg,
                                             input int width);
        logic [63:0] m;
        logic [63:0] v;
        m = (mag + (64'd1 << 13)) >> 14;
        v = neg ? (64'd0 - m) : m;
        return v[17:0] & ((18'd1 << width) - 18'd1);
    endfunction

    // Cosine of the angle, from a cosine or sine series of the reduced angle
    function automatic logic [63:0] cos_of_code(input logic [16:0] r);
        logic [63:0] one_q;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] kc [5];
        logic [63:0] ks [5];
        bit use_sin;
        one_q = 64'd1 << 30;
        kc = '{64'd90, 64'd56, 64'd30, 64'd12, 64'd2};
        ks = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        use_sin = r > 17'd16384;
        x = use_sin ? 64'(17'd32768 - r) : 64'(r);
        x = (x * 64'd3373259426 + 64'd32768) >> 16;
        x2 = mul_q30(x, x);
        t = one_q;
        for (int i = 0; i < 5; i++)
            t = one_q - mul_q30(x2, t) / (use_sin ? ks[i] : kc[i]);
        if (use_sin)
            t = mul_q30(x, t);
        return (t > one_q) ? one_q : t;
    endfunction

    // Expected matrix word for one angle under the current registers
    function automatic t_matrix predict_matrix(input logic [16:0] code);
        t_matrix res;
        logic [63:0] one_q;
        logic [63:0] c;
        logic [63:0] c2;
        logic [63:0] s2;
        logic [63:0] den;
        logic [63:0] delta;
        logic [63:0] ddnum;
        logic [63:0] dd;
        logic [63:0] p;
        bit cneg;
        bit ddneg;
        one_q = 64'd1 << 30;
        res = '{default: '0};
        if (code > 17'd65536) begin
            res.err = 1'b1;
            return res;
        end
        if (iso_mode) begin
            res.f11 = 17'd1 << FB;
            res.f22 = 17'd1 << FB;
            res.f33 = 18'd1 << FB;
            res.f44 = 18'd1 << FB;
            return res;
        end
        cneg = code > 17'd32768;
        c = cos_of_code(cneg ? 17'd65536 - code : code);
        c2 = mul_q30(c, c);
        s2 = one_q - c2;
        den = 64'd131072 + depol;
        delta = (((64'd65536 - depol) << 31) + den / 2) / den;
        ddneg = 2 * depol > 65536;
        ddnum = ddneg ? 64'd2 * depol - 64'd65536 : 64'd65536 - 64'd2 * depol;
        dd = ((ddnum << 31) + den / 2) / den;
        p = (64'd3 * mul_q30(delta, one_q + c2)) >> 2;
        res.f22 = 17'(to_fixed(p, 0, 17));
        res.f11 = 17'(to_fixed(p + one_q - delta, 0, 17));
        res.f12 = 17'(to_fixed((64'd3 * mul_q30(delta, s2)) >> 2, 1, 17));
        res.f33 = to_fixed((64'd3 * mul_q30(delta, c)) >> 1, cneg, 18);
        res.f44 = to_fixed((64'd3 * mul_q30(dd, c)) >> 1, cneg != ddneg, 18);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string field, input logic [17:0] got,
                                   input logic [17:0] want);
        $display("mismatch %s: got %h, expected %h at cycle %0d",
                 field, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Send one angle word; returns at the edge where it is accepted
    task automatic send_angle(input logic [16:0] code);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_angle_code <= code;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_matrix_q.push_back(predict_matrix(code));
    endtask

    // Stop sending and let every outstanding word come out
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (expected_matrix_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Write one register while the block is idle
    task automatic set_register(input logic idx, input logic [15:0] value);
        drain_pipe();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ISO)
            iso_mode = value[0];
        else
            depol = value;
    endtask

    function automatic logic [16:0] random_angle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 17'($urandom_range(65537, 131071));
        if (r < 12)
            return (r < 10) ? 17'd0 : 17'd65536;
        return 17'($urandom_range(0, 65536));
    endfunction

    // Angle extremes, quadrant boundaries and invalid codes at d = 0
    task automatic test_angle_edges();
        logic [16:0] codes [12];
        codes = '{17'd0, 17'd1, 17'd16383, 17'd16384, 17'd16385, 17'd32767,
                  17'd32768, 17'd32769, 17'd49152, 17'd65535, 17'd65536, 17'd65537};
        foreach (codes[i]) send_angle(codes[i]);
        send_angle(17'd131071);
    endtask

    // Depolarization extremes, including the sign flip of delta*delta'
    task automatic test_depolarization_edges();
        logic [15:0] dvals [5];
        dvals = '{16'd65535, 16'd32768, 16'd32769, 16'd32767, 16'd1};
        foreach (dvals[i]) begin
            set_register(CFG_DEP, dvals[i]);
            send_angle(17'd0);
            send_angle(17'd40000);
        end
    endtask

    // Isotropic mode, with two valid angles and an invalid one
    task automatic test_isotropic();
        set_register(CFG_ISO, 16'hFFFF);
        send_angle(17'd12345);
        send_angle(17'd65536);
        send_angle(17'd70000);
        set_register(CFG_ISO, 16'hFFFE);
    endtask

    // Random angles over a series of register settings
    task automatic test_random_angles();
        for (int phase = 0; phase < 10; phase++) begin
            calm = (phase == 3);
            set_register(CFG_ISO, 16'({$urandom_range(0, 32767), phase % 5 == 4}));
            case ($urandom_range(0, 3))
                0: set_register(CFG_DEP, 16'd0);
                1: set_register(CFG_DEP, 16'd65535);
                default: set_register(CFG_DEP, 16'($urandom_range(0, 65535)));
            endcase
            for (int n = 0; n < 100; n++) send_angle(random_angle());
        end
        calm = 0;
    endtask

    // Output stall pattern: mostly ready, short and occasional long stalls
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (calm || $urandom_range(0, 99) < 70) begin
            i_out_ready <= 1'b1;
            ready_hold  <= $urandom_range(0, 12);
        end else begin
            i_out_ready <= 1'b0;
            ready_hold  <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                       : $urandom_range(0, 2);
        end
    end

    // Compare each accepted matrix word with the oldest prediction
    always @(posedge i_clk) begin
        t_matrix want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_matrix_q.size() == 0) begin
                $display("unexpected matrix word at cycle %0d", cycle_count);
                mismatch_count++;
            end else begin
                want = expected_matrix_q.pop_front();
                if (o_f11 !== want.f11) report_mismatch("f11", 18'(o_f11), 18'(want.f11));
                if (o_f12 !== want.f12) report_mismatch("f12", 18'(o_f12), 18'(want.f12));
                if (o_f22 !== want.f22) report_mismatch("f22", 18'(o_f22), 18'(want.f22));
                if (o_f33 !== want.f33) report_mismatch("f33", o_f33, want.f33);
                if (o_f44 !== want.f44) report_mismatch("f44", o_f44, want.f44);
                if (o_angle_error !== want.err)
                    report_mismatch("angle_error", 18'(o_angle_error), 18'(want.err));
            end
        end
    end

    // Timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_angle_code <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_ISO;
        i_cfg_data   <= '0;
        calm     = 0;
        iso_mode = 1'b0;
        depol    = 16'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_angle_edges();
        test_depolarization_edges();
        test_isotropic();
        test_random_angles();
        drain_pipe();

        if (mismatch_count == 0 && expected_matrix_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
